[hw/rtl/cla_pkg.sv]
// shared constants and types of the crlf line assembler
// no dependencies; imported by the interfaces, cla_emit and crlf_line_assembler
`default_nettype none

package cla_pkg;

  localparam int unsigned MaxLineChars = 15;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned CntW         = $clog2(MaxLineChars + 1);
  localparam int unsigned AddrW        = (MaxLineChars > 1) ? $clog2(MaxLineChars) : 1;

  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;

  // request from the store side to the line emitter
  typedef struct packed {
    logic            start;
    logic [CntW-1:0] len;
  } emit_req_t;

endpackage

`default_nettype wire

[hw/rtl/cla_if.sv]
// valid/ready channel interfaces of the crlf line assembler
// depends on cla_pkg for the byte width
`default_nettype none

interface cla_in_if import cla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cla_out_if import cla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] line_char;
  logic             char_present;
  logic             line_last;

  modport source (output valid, output line_char, output char_present, output line_last,
                  input ready);
  modport sink   (input valid, input line_char, input char_present, input line_last,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/cla_line_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies; holds the characters of the current line
`default_nettype none

module cla_line_ram #(
  parameter  int unsigned Depth = 15,
  parameter  int unsigned Width = 8,
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/cla_emit.sv]
// line emitter: walks the line ram and presents one result per transfer
// depends on cla_pkg and cla_out_if; the ram read data acts as the output register
`default_nettype none

module cla_emit import cla_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire emit_req_t        req_i,
  output logic                  busy_o,
  output logic      [AddrW-1:0] raddr_o,
  input  wire logic [ByteW-1:0] rdata_i,
  cla_out_if.source             line_o
);

  logic            busy_q, busy_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] len_q, len_d;
  logic            empty_q, empty_d;
  logic [CntW-1:0] idx_nxt;
  logic            fire;
  logic            last;

  assign idx_nxt = idx_q + CntW'(1);
  assign fire    = busy_q && line_o.ready;
  assign last    = empty_q || (idx_nxt == len_q);

  // read address: entry zero while idle, next entry once this one is taken
  always_comb begin
    priority if (!busy_q) begin
      raddr_o = '0;
    end else if (fire && !last) begin
      raddr_o = idx_nxt[AddrW-1:0];
    end else begin
      raddr_o = idx_q[AddrW-1:0];
    end
  end

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    len_d   = len_q;
    empty_d = empty_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      idx_d   = '0;
      len_d   = req_i.len;
      empty_d = (req_i.len == '0);
    end else if (fire) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      idx_q   <= '0;
      len_q   <= '0;
      empty_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      empty_q <= empty_d;
    end
  end

  assign busy_o              = busy_q;
  assign line_o.valid        = busy_q;
  assign line_o.line_char    = empty_q ? '0 : rdata_i;
  assign line_o.char_present = !empty_q;
  assign line_o.line_last    = last;

  // a running line never walks past its trimmed length
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !empty_q |-> idx_q < len_q)
    else $error("emit index beyond line length");

  // a new line is only started while no line is being emitted
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("line start while emitting");

  // the final result closes the line
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last |=> !busy_q)
    else $error("emitter still busy after last transfer");

endmodule

`default_nettype wire

[hw/rtl/crlf_line_assembler.sv]
// top level of the crlf line assembler: byte intake, line counters, ram and emitter
// depends on cla_pkg, cla_if, cla_line_ram and cla_emit
//
// usage
//   rx_i carries one received byte per transfer. line_o carries the completed
//   line, one character per transfer, with line_last on the final one. a line
//   that is empty or all spaces after trimming gives one transfer with
//   char_present low and line_char zero.
//   characters beyond the maximum line length are dropped; a cr that is not
//   followed by lf is kept as an ordinary character.
// intake and output rate
//   an ordinary byte is written to the ram as it is taken; a cr that follows
//   a pending cr stores the earlier cr at once. any other byte that follows a
//   pending cr is queued behind the stored cr, holding off intake, since both
//   go through the single ram write port. the lf that closes a line shows the
//   first result in the next cycle, then one result per cycle while the
//   receiver takes them; intake stays held off until the last one is taken.
//   the single read port of the line ram sets that one-per-cycle rate.
// reset
//   counters and the pending cr flag clear; the ram is not cleared, its
//   entries are always written before they are read.
// stall
//   while the receiver stalls, the result holds and rx_i.ready stays low.
`default_nettype none

module crlf_line_assembler import cla_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cla_in_if.sink    rx_i,
  cla_out_if.source line_o
);

  // intake state
  logic             cr_pending_q, cr_pending_d;
  logic [CntW-1:0]  stored_count_q, stored_count_d;
  logic [CntW-1:0]  trimmed_q, trimmed_d;
  // second character queued when a pending cr turns into a stored cr
  logic             hold_vld_q, hold_vld_d;
  logic [ByteW-1:0] hold_byte_q, hold_byte_d;

  logic             accept;
  logic             store_vld;
  logic [ByteW-1:0] store_byte;
  logic             ram_we;
  logic [AddrW-1:0] ram_raddr;
  logic [ByteW-1:0] ram_rdata;
  emit_req_t        emit_req;
  logic             emit_busy;

  // no intake while a line is emitted or a queued character is written
  assign rx_i.ready = !emit_busy && !hold_vld_q;
  assign accept     = rx_i.valid && rx_i.ready;

  // decode one transfer into at most one ram write now and one queued
  always_comb begin
    cr_pending_d   = cr_pending_q;
    hold_vld_d     = 1'b0;
    hold_byte_d    = hold_byte_q;
    store_vld      = 1'b0;
    store_byte     = rx_i.rx_byte;
    emit_req.start = 1'b0;
    emit_req.len   = trimmed_q;
    priority if (hold_vld_q) begin
      store_vld  = 1'b1;
      store_byte = hold_byte_q;
    end else if (accept) begin
      if (cr_pending_q) begin
        if (rx_i.rx_byte == ChLf) begin
          // cr lf closes the line
          emit_req.start = 1'b1;
          cr_pending_d   = 1'b0;
        end else begin
          // the earlier cr becomes a character
          store_vld  = 1'b1;
          store_byte = ChCr;
          if (rx_i.rx_byte == ChCr) begin
            cr_pending_d = 1'b1;
          end else begin
            cr_pending_d = 1'b0;
            hold_vld_d   = 1'b1;
            hold_byte_d  = rx_i.rx_byte;
          end
        end
      end else if (rx_i.rx_byte == ChCr) begin
        cr_pending_d = 1'b1;
      end else begin
        store_vld = 1'b1;
      end
    end else begin
      // no transfer and nothing queued: intake state holds
    end
  end

  // character write and length tracking
  always_comb begin
    stored_count_d = stored_count_q;
    trimmed_d      = trimmed_q;
    ram_we         = 1'b0;
    if (emit_req.start) begin
      stored_count_d = '0;
      trimmed_d      = '0;
    end else if (store_vld && (stored_count_q < CntW'(MaxLineChars))) begin
      ram_we         = 1'b1;
      stored_count_d = stored_count_q + CntW'(1);
      if (store_byte != ChSpace) begin
        trimmed_d = stored_count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_pending_q   <= 1'b0;
      stored_count_q <= '0;
      trimmed_q      <= '0;
      hold_vld_q     <= 1'b0;
    end else begin
      cr_pending_q   <= cr_pending_d;
      stored_count_q <= stored_count_d;
      trimmed_q      <= trimmed_d;
      hold_vld_q     <= hold_vld_d;
    end
  end

  // queued character payload needs no reset
  always_ff @(posedge clk_i) begin
    hold_byte_q <= hold_byte_d;
  end

  cla_line_ram #(
    .Depth (MaxLineChars),
    .Width (ByteW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (stored_count_q[AddrW-1:0]),
    .wdata_i (store_byte),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cla_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (emit_req),
    .busy_o  (emit_busy),
    .raddr_o (ram_raddr),
    .rdata_i (ram_rdata),
    .line_o  (line_o)
  );

  // stored count never exceeds the line ram depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_count_q <= CntW'(MaxLineChars))
    else $error("stored count beyond line length");

  // trimmed length is a prefix of what is stored
  a_trim_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trimmed_q <= stored_count_q)
    else $error("trimmed length beyond stored count");

  // a queued character is written in the very next cycle, never twice
  a_hold_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |=> !hold_vld_q)
    else $error("queued character held more than one cycle");

  // ram is never written while the emitter reads it
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_busy |-> !ram_we)
    else $error("line ram written during emission");

  // closing a line starts the emitter
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_req.start |=> emit_busy)
    else $error("emitter did not start");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// testbench of the crlf line assembler: directed and random byte streams, results checked
// against a line predictor kept in the bench; depends on cla_pkg, cla_if and the rtl top
`timescale 1ns / 100ps

module tb_top;
  import cla_pkg::*;

  // generous ceiling: a few hundred items, each result possibly after a random receiver stall, one long hold
  localparam int unsigned CycleLimit   = 100000;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned RandomItems  = 100;
  localparam int unsigned QuietItems   = 40;

  // one expected transfer on the line output
  typedef struct packed {
    logic [ByteW-1:0] line_char;
    logic             char_present;
    logic             line_last;
  } line_result_t;

  logic clk_i;
  logic rst_ni;

  cla_in_if  rx_if ();
  cla_out_if line_if ();

  crlf_line_assembler uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if.sink),
    .line_o (line_if.source)
  );

  // predictor state: characters of the line being assembled
  logic [ByteW-1:0] line_buf [MaxLineChars];
  int unsigned      buf_count;
  int unsigned      trim_len;
  bit               cr_held;

  line_result_t     expected_q [$];

  int unsigned fail_count  = 0;
  int unsigned items_sent  = 0;
  int unsigned cyc_count   = 0;
  bit          tx_idle_en  = 1'b1;
  bit          rx_idle_en  = 1'b1;
  bit          long_hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // clock, reset and cycle ceiling
  // ---------------------------------------------------------------------------
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count == CycleLimit) begin
      $display("crlf_line_assembler: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // line predictor
  // ---------------------------------------------------------------------------
  // keep one character if the line still has room; spaces do not move the trim point
  function automatic void keep_char(input logic [ByteW-1:0] c);
    if (buf_count < MaxLineChars) begin
      line_buf[buf_count] = c;
      buf_count++;
      if (c != ChSpace) begin
        trim_len = buf_count;
      end
    end
  endfunction

  // cr lf seen: queue the trimmed line, or one empty marker
  function automatic void close_line();
    line_result_t r;
    if (trim_len == 0) begin
      r.line_char    = '0;
      r.char_present = 1'b0;
      r.line_last    = 1'b1;
      expected_q.push_back(r);
    end else begin
      for (int unsigned i = 0; i < trim_len; i++) begin
        r.line_char    = line_buf[i];
        r.char_present = 1'b1;
        r.line_last    = (i + 1 == trim_len);
        expected_q.push_back(r);
      end
    end
    buf_count = 0;
    trim_len  = 0;
    cr_held   = 1'b0;
  endfunction

  function automatic void assemble_byte(input logic [ByteW-1:0] c);
    if (cr_held) begin
      if (c == ChLf) begin
        close_line();
        return;
      end
      // cr not followed by lf is an ordinary character
      keep_char(ChCr);
      cr_held = 1'b0;
    end
    if (c == ChCr) begin
      cr_held = 1'b1;
    end else begin
      keep_char(c);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every output transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    line_result_t want;
    if (rst_ni && line_if.valid && line_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transfer: line_char %h char_present %b line_last %b",
               line_if.line_char, line_if.char_present, line_if.line_last);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (line_if.line_char !== want.line_char) begin
          $error("line_char: expected %h, got %h", want.line_char, line_if.line_char);
          fail_count++;
        end
        if (line_if.char_present !== want.char_present) begin
          $error("char_present: expected %b, got %b", want.char_present, line_if.char_present);
          fail_count++;
        end
        if (line_if.line_last !== want.line_last) begin
          $error("line_last: expected %b, got %b", want.line_last, line_if.line_last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random ready bursts, one long hold when asked
  // ---------------------------------------------------------------------------
  initial begin
    line_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        // hold off long enough for intake to back up behind the emitter
        long_hold_req = 1'b0;
        line_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
        line_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        line_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  // one byte transfer, optionally after an idle burst; valid stays up after the
  // transfer so back-to-back bytes follow without a gap
  task automatic send_byte(input logic [ByteW-1:0] b);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    assemble_byte(b);
    items_sent++;
  endtask

  task automatic send_crlf();
    send_byte(ChCr);
    send_byte(ChLf);
  endtask

  // stop offering and wait for every queued result
  task automatic drain_lines();
    rx_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // mostly printable text, with spaces, cr and arbitrary bytes mixed in
  function automatic logic [ByteW-1:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1:    return ChSpace;
      2:       return ChCr;
      3:       return ByteW'($urandom_range(0, 255));
      default: return ByteW'($urandom_range(8'h21, 8'h7E));
    endcase
  endfunction

  // well-formed lines most of the time, some noise and broken terminators
  task automatic send_random_line();
    int unsigned len;
    case ($urandom_range(0, 9))
      0: begin
        // raw noise, no terminator
        repeat ($urandom_range(1, 4)) send_byte(ByteW'($urandom_range(0, 255)));
      end
      1: begin
        // cr followed by something other than lf
        repeat ($urandom_range(0, 3)) send_byte(pick_char());
        send_byte(ChCr);
        send_byte(pick_char());
      end
      default: begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 8);
        repeat (len) send_byte(pick_char());
        repeat ($urandom_range(0, 2)) send_byte(ChSpace);
        send_crlf();
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // empty line, all-space line and a line with a trailing space to trim
  task automatic test_short_lines();
    send_crlf();
    send_byte(ChSpace);
    send_byte(ChSpace);
    send_crlf();
    send_byte(8'h78);
    send_byte(ChSpace);
    send_crlf();
    drain_lines();
  endtask

  // byte extremes, bare lf, lone cr, cr cr, and a line past the length limit
  task automatic test_overlong_line();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChLf);     // lf without cr is stored as text
    send_byte(ChCr);
    send_byte(8'h41);    // resolves the lone cr into a stored character
    send_byte(ChCr);
    send_byte(ChCr);     // first cr stored, second stays pending
    send_byte(ChSpace);
    repeat (9) send_byte(ByteW'($urandom_range(8'h21, 8'h7E)));
    send_crlf();
    drain_lines();
  endtask

  // receiver holds off while the sender keeps offering whole lines
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    repeat (12) send_byte(pick_char());
    send_crlf();
    repeat (6) send_byte(pick_char());
    send_crlf();
    send_crlf();
    drain_lines();
  endtask

  task automatic test_random_lines(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_line();
    // close any open line so its characters get checked
    send_crlf();
    drain_lines();
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_lines(QuietItems);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    buf_count = 0;
    trim_len  = 0;
    cr_held   = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_lines();
    test_overlong_line();
    test_backpressure();
    test_random_lines(RandomItems);
    test_full_rate();

    rx_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    // let any stray transfer surface before the verdict
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("crlf_line_assembler: match");
    end else begin
      $display("crlf_line_assembler: mismatch");
    end
    $finish;
  end

endmodule
